@@ rtl/gated_kalman_position_filter_assert.svh @@
// ---------------------------------------------------------------------------
// gated_kalman_position_filter assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef GATED_KALMAN_POSITION_FILTER_ASSERT_SVH
`define GATED_KALMAN_POSITION_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
// check sampled on the rising clock, masked while reset is active
`define GKPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on the rising clock, reset included
`define GKPF_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GKPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define GKPF_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/gkpf_pkg.sv @@
// ---------------------------------------------------------------------------
// gkpf_pkg
// Types and constants of the gated constant-position Kalman filter.
// ---------------------------------------------------------------------------
package gkpf_pkg;

    // fixed-point format
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned AXES      = 3;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned AX_W      = 2;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned IDX_W     = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GATE_THR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PROC_VAR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEAS_VAR  = 2'd2;
    localparam logic [IDX_W-1:0] REG_START_VAR = 2'd3;

    // reset values, rounded and saturated to 32 bits
    localparam logic [63:0] GATE_RAW  = ((64'd7815 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] PROC_RAW  = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] MEAS_RAW  = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] START_RAW = 64'd1000 << FRAC_BITS;
    localparam logic [63:0] U32_MAX   = 64'h0000_0000_FFFF_FFFF;

    localparam logic [WORD_W-1:0] GATE_THR_RST  =
        (GATE_RAW > U32_MAX) ? '1 : GATE_RAW[WORD_W-1:0];
    localparam logic [WORD_W-1:0] PROC_VAR_RST  =
        (PROC_RAW > U32_MAX) ? '1 : PROC_RAW[WORD_W-1:0];
    localparam logic [WORD_W-1:0] MEAS_VAR_RST  =
        (MEAS_RAW > U32_MAX) ? '1 : MEAS_RAW[WORD_W-1:0];
    localparam logic [WORD_W-1:0] START_VAR_RST =
        (START_RAW > U32_MAX) ? '1 : START_RAW[WORD_W-1:0];

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PREP,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_RES,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // operation running on the shared multiplier and divider
    typedef enum logic [1:0] {
        OP_GATE,
        OP_EST,
        OP_VAR
    } op_t;

endpackage

@@ rtl/gated_kalman_position_filter.sv @@
// ---------------------------------------------------------------------------
// gated_kalman_position_filter
// Three scalar Kalman filters sharing one chi-square gate, worked axis by
// axis on one 32x32 multiplier and one radix-2 divider.
// ---------------------------------------------------------------------------
// Usage
//   s_ channel: one transfer carries a measured position (x, y, z).
//   m_ channel: one transfer per input with the filtered position and flags.
//   cfg port: gate threshold, q, r and start variance, written while idle.
// Sequence
//   first item after reset: loads the filter and passes through
//   item failing the gate: three gate divisions
//   item passing the gate: three gate divisions plus six
//   update divisions; each division runs on the shared divider,
//   one quotient bit per cycle unless the quotient saturates, and sets the rate.
//   s_tready is high only while the sequencer is idle, one item at a time.
// Reset
//   clears the sequencer, the output valid and the primed flag and loads the
//   default register values; the next item initialises the filter.
// Receiver stall
//   the result waits in the output register; the next item is taken and
//   worked meanwhile, and its result waits for the register to free up.
// ---------------------------------------------------------------------------
module gated_kalman_position_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,   // obs_x, obs_y, obs_z
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [95:0]                     m_tdata,   // filt_x, filt_y, filt_z
    output logic [1:0]                      m_tuser,   // rejected, first_sample
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [gkpf_pkg::IDX_W-1:0]      cfg_index,
    input  logic [gkpf_pkg::WORD_W-1:0]     cfg_wdata
);

    localparam int unsigned W = gkpf_pkg::WORD_W;

    // configuration registers
    logic [W-1:0] gate_thr_reg, proc_var_reg, meas_var_reg, start_var_reg;

    // sequencer
    gkpf_pkg::state_t                 state_reg, state_next;
    gkpf_pkg::op_t                    op_reg, op_next;
    logic [gkpf_pkg::AX_W-1:0]        ax_reg, ax_next;
    logic [gkpf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             primed_reg, primed_next;

    // filter state and per-axis working values
    logic [2:0][W-1:0] obs_reg, obs_next;
    logic [2:0][W-1:0] est_reg, est_next;
    logic [2:0][W-1:0] var_reg, var_next;
    logic [2:0][W-1:0] pv_reg, pv_next;
    logic [2:0][W-1:0] s_reg, s_next;
    logic [2:0][W-1:0] mag_reg, mag_next;
    logic [2:0]        neg_reg, neg_next;
    logic [W-1:0]      gate_reg, gate_next;
    logic              rej_reg, rej_next;
    logic              first_reg, first_next;

    // shared divider: remainder and dividend/quotient shift register
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] lo_reg, lo_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [95:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    // datapath wires
    logic              s_accept;
    logic [W-1:0]      s_cur;
    logic [W:0]        y_diff, y_neg;
    logic [W:0]        pv_sum, s_sum;
    logic [W-1:0]      pv_sat, s_sat;
    logic [W-1:0]      mul_a, mul_b;
    logic [2*W-1:0]    product;
    logic [W:0]        div_shl, div_sub;
    logic              div_ge;
    logic [W:0]        gate_sum;
    logic              out_free;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == gkpf_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign s_cur    = s_reg[ax_reg];

    // innovation and predicted variances of the current axis
    always_comb begin
        y_diff = {obs_reg[ax_reg][W-1], obs_reg[ax_reg]} -
                 {est_reg[ax_reg][W-1], est_reg[ax_reg]};
        y_neg  = -y_diff;
        pv_sum = {1'b0, var_reg[ax_reg]} + {1'b0, proc_var_reg};
        pv_sat = pv_sum[W] ? '1 : pv_sum[W-1:0];
        s_sum  = {1'b0, pv_sat} + {1'b0, meas_var_reg};
        s_sat  = s_sum[W] ? '1 : s_sum[W-1:0];
        if (s_sat == '0) begin
            s_sat = {{(W-1){1'b0}}, 1'b1};
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a   = (op_reg == gkpf_pkg::OP_VAR)  ? pv_reg[ax_reg] : mag_reg[ax_reg];
        mul_b   = (op_reg == gkpf_pkg::OP_GATE) ? mag_reg[ax_reg] : pv_reg[ax_reg];
        product = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
    end

    // one restoring division step
    always_comb begin
        div_shl = {rem_reg, lo_reg[W-1]};
        div_sub = div_shl - {1'b0, s_cur};
        div_ge  = (div_shl >= {1'b0, s_cur});
    end

    // saturating gate accumulate
    assign gate_sum = {1'b0, gate_reg} + {1'b0, lo_reg};

    // sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        ax_next      = ax_reg;
        cnt_next     = cnt_reg;
        primed_next  = primed_reg;
        obs_next     = obs_reg;
        est_next     = est_reg;
        var_next     = var_reg;
        pv_next      = pv_reg;
        s_next       = s_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        gate_next    = gate_reg;
        rej_next     = rej_reg;
        first_next   = first_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        // output transfer frees the register
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            gkpf_pkg::ST_IDLE: begin
                if (s_accept) begin
                    obs_next   = {s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]};
                    rej_next   = 1'b0;
                    first_next = !primed_reg;
                    gate_next  = '0;
                    ax_next    = '0;
                    op_next    = gkpf_pkg::OP_GATE;
                    state_next = primed_reg ? gkpf_pkg::ST_PREP : gkpf_pkg::ST_INIT;
                end
            end
            // first sample loads the filter
            gkpf_pkg::ST_INIT: begin
                for (int i = 0; i < 3; i++) begin
                    est_next[i] = obs_reg[i];
                    var_next[i] = start_var_reg;
                end
                primed_next = 1'b1;
                state_next  = gkpf_pkg::ST_OUT;
            end
            // per-axis predicted variance and innovation
            gkpf_pkg::ST_PREP: begin
                pv_next[ax_reg]  = pv_sat;
                s_next[ax_reg]   = s_sat;
                neg_next[ax_reg] = y_diff[W];
                mag_next[ax_reg] = y_diff[W] ? y_neg[W-1:0] : y_diff[W-1:0];
                state_next       = gkpf_pkg::ST_MUL;
            end
            gkpf_pkg::ST_MUL: begin
                rem_next   = product[2*W-1:W];
                lo_next    = product[W-1:0];
                state_next = gkpf_pkg::ST_CHK;
            end
            // quotient that would not fit in 32 bits saturates
            gkpf_pkg::ST_CHK: begin
                cnt_next = '0;
                if (rem_reg >= s_cur) begin
                    lo_next    = '1;
                    state_next = gkpf_pkg::ST_RES;
                end else begin
                    state_next = gkpf_pkg::ST_DIV;
                end
            end
            gkpf_pkg::ST_DIV: begin
                rem_next = div_ge ? div_sub[W-1:0] : div_shl[W-1:0];
                lo_next  = {lo_reg[W-2:0], div_ge};
                if (cnt_reg == '1) begin
                    cnt_next   = '0;
                    state_next = gkpf_pkg::ST_RES;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // use the quotient
            gkpf_pkg::ST_RES: begin
                case (op_reg)
                    gkpf_pkg::OP_GATE: begin
                        gate_next = gate_sum[W] ? '1 : gate_sum[W-1:0];
                        if (ax_reg == gkpf_pkg::AX_W'(gkpf_pkg::AXES - 1)) begin
                            state_next = gkpf_pkg::ST_DECIDE;
                        end else begin
                            ax_next    = ax_reg + 1'b1;
                            state_next = gkpf_pkg::ST_PREP;
                        end
                    end
                    gkpf_pkg::OP_EST: begin
                        est_next[ax_reg] = neg_reg[ax_reg] ? est_reg[ax_reg] - lo_reg
                                                           : est_reg[ax_reg] + lo_reg;
                        op_next    = gkpf_pkg::OP_VAR;
                        state_next = gkpf_pkg::ST_MUL;
                    end
                    default: begin
                        var_next[ax_reg] = pv_reg[ax_reg] - lo_reg;
                        if (ax_reg == gkpf_pkg::AX_W'(gkpf_pkg::AXES - 1)) begin
                            state_next = gkpf_pkg::ST_OUT;
                        end else begin
                            ax_next    = ax_reg + 1'b1;
                            op_next    = gkpf_pkg::OP_EST;
                            state_next = gkpf_pkg::ST_MUL;
                        end
                    end
                endcase
            end
            // gate decision
            gkpf_pkg::ST_DECIDE: begin
                if (gate_reg > gate_thr_reg) begin
                    rej_next = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        var_next[i] = pv_reg[i];
                    end
                    state_next = gkpf_pkg::ST_OUT;
                end else begin
                    ax_next    = '0;
                    op_next    = gkpf_pkg::OP_EST;
                    state_next = gkpf_pkg::ST_MUL;
                end
            end
            // hand the result to the output register
            gkpf_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {est_reg[2], est_reg[1], est_reg[0]};
                    m_user_next  = {first_reg, rej_reg};
                    state_next   = gkpf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gkpf_pkg::ST_IDLE;
            end
        endcase
    end

    // state register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gkpf_pkg::ST_IDLE;
            op_reg      <= gkpf_pkg::OP_GATE;
            ax_reg      <= '0;
            cnt_reg     <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            ax_reg      <= ax_next;
            cnt_reg     <= cnt_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        obs_reg    <= obs_next;
        est_reg    <= est_next;
        var_reg    <= var_next;
        pv_reg     <= pv_next;
        s_reg      <= s_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        gate_reg   <= gate_next;
        rej_reg    <= rej_next;
        first_reg  <= first_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_thr_reg  <= gkpf_pkg::GATE_THR_RST;
            proc_var_reg  <= gkpf_pkg::PROC_VAR_RST;
            meas_var_reg  <= gkpf_pkg::MEAS_VAR_RST;
            start_var_reg <= gkpf_pkg::START_VAR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gkpf_pkg::REG_GATE_THR:  gate_thr_reg  <= cfg_wdata;
                gkpf_pkg::REG_PROC_VAR:  proc_var_reg  <= cfg_wdata;
                gkpf_pkg::REG_MEAS_VAR:  meas_var_reg  <= cfg_wdata;
                gkpf_pkg::REG_START_VAR: start_var_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // checks
`include "gated_kalman_position_filter_assert.svh"

    `GKPF_ASSERT(a_div_rem_below_divisor, aclk, aresetn, (state_reg == gkpf_pkg::ST_DIV) |-> (rem_reg < s_cur), "divider remainder not below divisor")
    `GKPF_ASSERT(a_cnt_idle_outside_div, aclk, aresetn, (state_reg != gkpf_pkg::ST_DIV) |-> (cnt_reg == '0), "step counter running outside division")
    `GKPF_ASSERT(a_unprimed_inits, aclk, aresetn, (s_accept && !primed_reg) |=> (state_reg == gkpf_pkg::ST_INIT), "unprimed item did not initialise")
    `GKPF_ASSERT(a_gate_then_decide, aclk, aresetn, (state_reg == gkpf_pkg::ST_RES && op_reg == gkpf_pkg::OP_GATE && ax_reg == 2'd2) |=> (state_reg == gkpf_pkg::ST_DECIDE), "gate sum not followed by decision")
    `GKPF_ASSERT_NORST(a_reset_idle, aclk, !aresetn |=> (state_reg == gkpf_pkg::ST_IDLE && !m_valid_reg && !primed_reg), "reset did not clear control state")

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gated constant-position Kalman filter. A
// scoreboard class mirrors the three scalar filters and the shared gate in
// fixed point and queues one expected fix per measurement; every transfer
// on the result stream is compared field by field with the oldest entry.
// Directed measurements hit the first sample, variance and gate saturation,
// a zero innovation variance and truncation toward zero, then random
// phases with different register settings and idling patterns follow.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int     CYCLE_LIMIT   = 4_000_000;
    localparam int     SETTLE_CYCLES = 400;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 250;
    localparam longint POS_MAX       = 64'sd2147483647;
    localparam longint POS_MIN       = -64'sd2147483648;

    // one expected result transfer
    typedef struct packed {
        logic [31:0] filt_x;
        logic [31:0] filt_y;
        logic [31:0] filt_z;
        logic        rejected;
        logic        first_sample;
    } fix_t;

    // mirror of the filter state and the queue of expected fixes
    class kalman_scoreboard;
        logic [31:0]       gate_thr;
        logic [31:0]       proc_var;
        logic [31:0]       meas_var;
        logic [31:0]       start_var;
        bit                primed;
        logic [2:0][31:0]  est_pos;
        logic [2:0][31:0]  est_var;
        fix_t              expected_fixes[$];
        int                mismatches;

        function new();
            gate_thr   = gkpf_pkg::GATE_THR_RST;
            proc_var   = gkpf_pkg::PROC_VAR_RST;
            meas_var   = gkpf_pkg::MEAS_VAR_RST;
            start_var  = gkpf_pkg::START_VAR_RST;
            primed     = 1'b0;
            est_pos    = '0;
            est_var    = '0;
            mismatches = 0;
        endfunction

        function logic [63:0] sat32(logic [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
        endfunction

        // run one measurement through the filter and queue its fix
        function void record_obs(logic [95:0] obs_w);
            longint            obs;
            longint            innov;
            logic [2:0][63:0]  pv;
            logic [2:0][63:0]  sv;
            logic [2:0][63:0]  mag;
            logic [2:0]        neg;
            logic [63:0]       gate;
            logic [63:0]       term;
            logic [63:0]       delta;
            fix_t              fix;
            int                i;
            fix.rejected     = 1'b0;
            fix.first_sample = 1'b0;
            gate             = '0;
            if (!primed) begin
                // first sample loads the filter and passes through
                for (i = 0; i < 3; i++) begin
                    est_pos[i] = obs_w[32*i +: 32];
                    est_var[i] = start_var;
                end
                primed           = 1'b1;
                fix.first_sample = 1'b1;
            end else begin
                // prediction, innovation and gate sum
                for (i = 0; i < 3; i++) begin
                    obs    = $signed(obs_w[32*i +: 32]);
                    innov  = obs - longint'($signed(est_pos[i]));
                    pv[i]  = sat32(64'(est_var[i]) + 64'(proc_var));
                    sv[i]  = sat32(pv[i] + 64'(meas_var));
                    if (sv[i] == 64'd0) begin
                        sv[i] = 64'd1;
                    end
                    neg[i] = innov < 0;
                    mag[i] = neg[i] ? 64'(-innov) : 64'(innov);
                    term   = sat32((mag[i] * mag[i]) / sv[i]);
                    gate   = sat32(gate + term);
                end
                fix.rejected = gate > 64'(gate_thr);
                // update, or keep the prediction on a gate failure
                for (i = 0; i < 3; i++) begin
                    if (fix.rejected) begin
                        est_var[i] = pv[i][31:0];
                    end else begin
                        delta      = (mag[i] * pv[i]) / sv[i];
                        est_pos[i] = neg[i] ? est_pos[i] - delta[31:0]
                                            : est_pos[i] + delta[31:0];
                        est_var[i] = 32'(pv[i] - (pv[i] * pv[i]) / sv[i]);
                    end
                end
            end
            fix.filt_x = est_pos[0];
            fix.filt_y = est_pos[1];
            fix.filt_z = est_pos[2];
            expected_fixes.push_back(fix);
        endfunction

        function void field_check(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%s mismatch: expected %h, got %h", field, want, got);
                end
            end
        endfunction

        // compare one result transfer with the oldest expected fix
        function void check_filtered(logic [95:0] data, logic [1:0] user);
            fix_t want;
            if (expected_fixes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result with nothing expected: tdata %h tuser %b", data, user);
                end
                return;
            end
            want = expected_fixes.pop_front();
            field_check("filt_x", want.filt_x, data[31:0]);
            field_check("filt_y", want.filt_y, data[63:32]);
            field_check("filt_z", want.filt_z, data[95:64]);
            field_check("rejected", 32'(want.rejected), 32'(user[0]));
            field_check("first_sample", 32'(want.first_sample), 32'(user[1]));
        endfunction
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic [95:0]                   s_tdata   = '0;
    logic                          m_tready  = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [gkpf_pkg::IDX_W-1:0]    cfg_index = '0;
    logic [gkpf_pkg::WORD_W-1:0]   cfg_wdata = '0;
    wire                           s_tready;
    wire                           m_tvalid;
    wire  [95:0]                   m_tdata;
    wire  [1:0]                    m_tuser;

    int                  send_idle  = 0;
    int                  recv_stall = 0;
    int                  cycles     = 0;
    int                  ph;
    int                  n;
    kalman_scoreboard    sb;

    gated_kalman_position_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // obs_x, obs_y, obs_z
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // filt_x, filt_y, filt_z
        .m_tuser   (m_tuser),      // rejected, first_sample
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // result transfers
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_filtered(m_tdata, m_tuser);
        end
    end

    // run time guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // position plus offset, held inside the signed 32-bit range
    function automatic logic [31:0] clamp_add(logic [31:0] base, longint off);
        longint sum;
        sum = longint'($signed(base)) + off;
        if (sum > POS_MAX) begin
            sum = POS_MAX;
        end else if (sum < POS_MIN) begin
            sum = POS_MIN;
        end
        return sum[31:0];
    endfunction

    function automatic logic [95:0] near_est(longint dx, longint dy, longint dz);
        return {clamp_add(sb.est_pos[2], dz), clamp_add(sb.est_pos[1], dy),
                clamp_add(sb.est_pos[0], dx)};
    endfunction

    // measurement scattered around the estimate, scaled to the gate size
    function automatic logic [95:0] tracked_obs();
        logic [2:0][31:0] obs_w;
        logic [63:0]      s_est;
        logic [63:0]      bound;
        longint           off;
        int               i;
        for (i = 0; i < 3; i++) begin
            s_est = 64'(sb.est_var[i]) + 64'(sb.proc_var) + 64'(sb.meas_var);
            bound = (isqrt(s_est) * isqrt(64'(sb.gate_thr))) >> $urandom_range(0, 2);
            if (bound > 64'h7FFF_FFFF) begin
                bound = 64'h7FFF_FFFF;
            end
            off = (bound == 0) ? 0 : longint'({$urandom, $urandom} % (bound + 1));
            if ($urandom_range(0, 1) == 1) begin
                off = -off;
            end
            obs_w[i] = clamp_add(sb.est_pos[i], off);
        end
        return obs_w;
    endfunction

    // range limits and the current estimate mixed per axis
    function automatic logic [95:0] edge_obs();
        logic [2:0][31:0] obs_w;
        int               i;
        for (i = 0; i < 3; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    obs_w[i] = 32'h8000_0000;
                end
                1: begin
                    obs_w[i] = 32'h7FFF_FFFF;
                end
                2: begin
                    obs_w[i] = 32'h0;
                end
                default: begin
                    obs_w[i] = sb.est_pos[i];
                end
            endcase
        end
        return obs_w;
    endfunction

    function automatic logic [95:0] pick_obs();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return tracked_obs();
        end else if (pick < 85) begin
            return {$urandom, $urandom, $urandom};
        end
        return edge_obs();
    endfunction

    // one input transfer, entered and left at a falling edge
    task automatic send_obs(input logic [95:0] obs_w);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= obs_w;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.record_obs(obs_w);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [gkpf_pkg::IDX_W-1:0] idx,
                             input logic [gkpf_pkg::WORD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic program_filter(input logic [31:0] thr, input logic [31:0] q,
                                  input logic [31:0] r, input logic [31:0] start);
        write_reg(gkpf_pkg::REG_GATE_THR, thr);
        write_reg(gkpf_pkg::REG_PROC_VAR, q);
        write_reg(gkpf_pkg::REG_MEAS_VAR, r);
        write_reg(gkpf_pkg::REG_START_VAR, start);
        cfg_wr_en    <= 1'b0;
        sb.gate_thr  = thr;
        sb.proc_var  = q;
        sb.meas_var  = r;
        sb.start_var = start;
    endtask

    // stop sending and wait for every outstanding fix
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.expected_fixes.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: first sample, zero innovation, saturated gate, small steps
        send_obs({32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_obs({32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_obs({32'h0001_2345, 32'h7FFF_FFFF, 32'h8000_0000});
        send_obs(near_est(-8, 5, -3));
        send_obs(near_est(1, -1, 0));

        // saturated predicted and innovation variances
        quiesce();
        program_filter('1, '1, '1, 32'h0);
        send_obs({32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF});
        send_obs(near_est(-100, 100, 0));

        // zero innovation variance taken as one lsb, gate sum at the limit
        quiesce();
        program_filter('1, 32'h0, 32'h0, '1);
        send_obs(near_est(0, 0, 0));
        send_obs({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        send_obs(near_est(-1, 1, -1));

        // zero threshold: only a gate sum that truncates to zero passes
        quiesce();
        program_filter(32'h0, 32'h1, 32'h0, 32'd65536);
        send_obs(near_est(0, 0, 0));
        send_obs(near_est(1, 0, 0));
        send_obs(near_est(0, 0, -1));

        quiesce();
        program_filter(gkpf_pkg::GATE_THR_RST, gkpf_pkg::PROC_VAR_RST,
                       gkpf_pkg::MEAS_VAR_RST, gkpf_pkg::START_VAR_RST);
        send_obs(near_est(3, -3, 65536));

        // random phases, each with its own registers and idling pattern
        for (ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph % 4)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 84;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 84;
                end
                default: begin
                    send_idle  = 13;
                    recv_stall = 13;
                end
            endcase
            case (ph)
                0: begin
                    program_filter(gkpf_pkg::GATE_THR_RST, gkpf_pkg::PROC_VAR_RST,
                                   gkpf_pkg::MEAS_VAR_RST, gkpf_pkg::START_VAR_RST);
                end
                1: begin
                    program_filter($urandom, $urandom_range(0, 65536),
                                   $urandom_range(1, 1 << 20), $urandom);
                end
                2: begin
                    program_filter('1, 32'h0, 32'h1, 32'h0);
                end
                3: begin
                    program_filter(32'h0, '1, '1, '1);
                end
                4: begin
                    program_filter(65536 * $urandom_range(1, 20), $urandom_range(0, 4096),
                                   $urandom, $urandom);
                end
                5: begin
                    program_filter($urandom, $urandom, $urandom, $urandom);
                end
                6: begin
                    program_filter(32'h1, 32'h0, 32'h0, 32'h0);
                end
                default: begin
                    program_filter(gkpf_pkg::GATE_THR_RST, $urandom_range(0, 1024),
                                   gkpf_pkg::MEAS_VAR_RST, gkpf_pkg::START_VAR_RST);
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_obs(pick_obs());
            end
        end

        quiesce();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0 && sb.expected_fixes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gkpf_pkg.sv
rtl/gated_kalman_position_filter.sv
bench/tb_top.sv
